/* rtl/core/bsp_pkg.sv */
// Shared types and constants for the bounding sphere core.
// Used by the top level, bsp_dist and bsp_isqrt in rtl/core; depends on nothing else.
`timescale 1ns / 1ps

package bsp_pkg;

   // Default parameter values for the top level.
   localparam int DEF_MAX_POINTS  = 1024;
   localparam int DEF_COORD_BITS  = 16;

   // Fixed port field widths.
   localparam int FIELD_BITS      = 16;  // one input coordinate
   localparam int CENTER_BITS     = 17;  // one doubled center coordinate
   localparam int RADIUS_BITS     = 17;  // doubled radius
   localparam int COUNT_OUT_BITS  = 11;  // point count in the result
   localparam int IN_TDATA_BITS   = 48;
   localparam int OUT_TDATA_BITS  = 80;
   localparam int NUM_AXES        = 3;

   typedef enum logic [1:0] {
      AXIS_X,
      AXIS_Y,
      AXIS_Z
   } axis_type;

   typedef enum logic [2:0] {
      S_LOAD,
      S_CENTER,
      S_WALK,
      S_DRAIN,
      S_ROOT,
      S_EMIT
   } state_type;

   // Control from the sequencer to the distance unit.
   typedef struct packed {
      logic     clear;   // reset the running maximum
      logic     sq_en;   // square one axis of the current point
      axis_type axis;    // which axis
   } dist_ctl_type;

endpackage

/* rtl/core/bounding_sphere_from_points_core.sv */
// Top level of the bounding sphere core: sequencer, corner tracking, result
// register. Depends on bsp_pkg, bsp_ram, bsp_dist and bsp_isqrt.
`timescale 1ns / 1ps

// The core takes a set of 3D points, one item per point on the req_ channel,
// with req_tlast on the final point, and returns one item per set on the rsp_
// channel: the doubled center of the axis-aligned bounding box (min + max per
// axis), the floor square root of the largest doubled-unit squared distance
// from that center to any stored point, the number of points used and an
// overflow flag. Points are signed fixed point (Q7.8 at the default width).
// While a set is loading, one point is taken per cycle and written to the
// point memory; points beyond MAX_POINTS are dropped, do not move the box,
// and set the overflow flag, and a dropped last point still ends the set.
// After the last point the core stops taking items and walks the memory
// with a single shared squaring unit, one axis per cycle, squaring the three
// axes of each stored point in turn. An iterative root then produces one bit
// per cycle. Only after the walk and the root does the core load the result
// and accept the next set; the result register lets the next set load while
// a finished result still waits on rsp_tready. The point memory needs no
// clearing after reset, since only entries written in the current set are
// read.
module bounding_sphere_from_points_core
   import bsp_pkg::*;
#(
   parameter int MAX_POINTS = DEF_MAX_POINTS,
   parameter int COORD_BITS = DEF_COORD_BITS
) (
   input  logic                        clock,
   input  logic                        reset,
   // Point items.
   input  logic                        req_tvalid,
   output logic                        req_tready,
   input  logic [IN_TDATA_BITS-1:0]    req_tdata,  // point_x, point_y, point_z
   input  logic                        req_tlast,  // last_point
   // Result items.
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   output logic [OUT_TDATA_BITS-1:0]   rsp_tdata,  // center_x2, center_y2,
                                                   // center_z2, radius_x2,
                                                   // point_count, zero pad
   output logic                        rsp_tuser   // overflow
);

   localparam int ADDR_BITS = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
   localparam int CNT_BITS  = $clog2(MAX_POINTS + 1);
   localparam int RAW_BITS  = 2 * COORD_BITS + 2;
   localparam int SQ_BITS   = (RAW_BITS > 64) ? 64 : RAW_BITS;
   localparam int ROOT_BITS = SQ_BITS / 2;
   localparam int PT_BITS   = NUM_AXES * COORD_BITS;

   state_type state_ff, state_in;

   logic [CNT_BITS-1:0]          count_ff, count_in;
   logic                         dropped_ff, dropped_in;
   logic signed [COORD_BITS-1:0] min_ff [NUM_AXES];
   logic signed [COORD_BITS-1:0] min_in [NUM_AXES];
   logic signed [COORD_BITS-1:0] max_ff [NUM_AXES];
   logic signed [COORD_BITS-1:0] max_in [NUM_AXES];
   logic signed [COORD_BITS:0]   c2_ff  [NUM_AXES];
   logic signed [COORD_BITS:0]   c2_in  [NUM_AXES];
   logic [ADDR_BITS-1:0]         idx_ff, idx_in;
   axis_type                     axis_ff, axis_in;

   logic                         rsp_valid_ff, rsp_valid_in;
   logic [OUT_TDATA_BITS-1:0]    rsp_data_ff, rsp_data_in;
   logic                         rsp_user_ff, rsp_user_in;

   logic signed [COORD_BITS-1:0] pt [NUM_AXES];
   logic                         accept;
   logic                         has_room;
   logic                         last_idx;

   logic                         ram_wr_en;
   logic                         ram_rd_en;
   logic [ADDR_BITS-1:0]         ram_rd_addr;
   logic [PT_BITS-1:0]           ram_rd_data;

   dist_ctl_type                 dist_ctl;
   logic [RAW_BITS-1:0]          best;
   logic                         dist_busy;
   logic [SQ_BITS-1:0]           sq_opnd;
   logic                         root_start;
   logic                         root_done;
   logic [ROOT_BITS-1:0]         root;

   // Input coordinates, taken as COORD_BITS-wide signed values.
   always_comb begin
      for (int a = 0; a < NUM_AXES; a++) begin
         pt[a] = signed'(COORD_BITS'(req_tdata[a*FIELD_BITS +: FIELD_BITS]));
      end
   end

   assign accept   = req_tvalid && req_tready;
   assign has_room = (count_ff < CNT_BITS'(MAX_POINTS));
   assign last_idx = (CNT_BITS'(idx_ff) == CNT_BITS'(count_ff - 1'b1));

   // Sequencer: load, form the center, walk the store, take the root, emit.
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      dropped_in   = dropped_ff;
      min_in       = min_ff;
      max_in       = max_ff;
      c2_in        = c2_ff;
      idx_in       = idx_ff;
      axis_in      = axis_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_user_in  = rsp_user_ff;
      req_tready   = 1'b0;
      ram_wr_en    = 1'b0;
      ram_rd_en    = 1'b0;
      ram_rd_addr  = idx_ff;
      dist_ctl     = '{clear: 1'b0, sq_en: 1'b0, axis: axis_ff};
      root_start   = 1'b0;

      case (state_ff)
         S_LOAD: begin
            req_tready = 1'b1;
            if (accept) begin
               if (has_room) begin
                  ram_wr_en = 1'b1;
                  count_in  = count_ff + 1'b1;
                  // The first point of a set opens the box on its own.
                  for (int a = 0; a < NUM_AXES; a++) begin
                     if ((count_ff == '0) || (pt[a] < min_ff[a])) begin
                        min_in[a] = pt[a];
                     end
                     if ((count_ff == '0) || (pt[a] > max_ff[a])) begin
                        max_in[a] = pt[a];
                     end
                  end
               end else begin
                  dropped_in = 1'b1;
               end
               if (req_tlast) begin
                  state_in = S_CENTER;
               end
            end
         end

         S_CENTER: begin
            for (int a = 0; a < NUM_AXES; a++) begin
               c2_in[a] = (COORD_BITS+1)'(min_ff[a]) + (COORD_BITS+1)'(max_ff[a]);
            end
            dist_ctl.clear = 1'b1;
            ram_rd_en      = 1'b1;
            ram_rd_addr    = '0;
            idx_in         = '0;
            axis_in        = AXIS_X;
            state_in       = S_WALK;
         end

         S_WALK: begin
            dist_ctl.sq_en = 1'b1;
            case (axis_ff)
               AXIS_X: axis_in = AXIS_Y;
               AXIS_Y: axis_in = AXIS_Z;
               default: begin
                  axis_in = AXIS_X;
                  if (last_idx) begin
                     state_in = S_DRAIN;
                  end else begin
                     // Fetch the next point while the last axis is squared.
                     idx_in      = ADDR_BITS'(idx_ff + 1'b1);
                     ram_rd_en   = 1'b1;
                     ram_rd_addr = ADDR_BITS'(idx_ff + 1'b1);
                  end
               end
            endcase
         end

         S_DRAIN: begin
            if (!dist_busy) begin
               root_start = 1'b1;
               state_in   = S_ROOT;
            end
         end

         S_ROOT: begin
            if (root_done) begin
               state_in = S_EMIT;
            end
         end

         S_EMIT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {1'b0,
                               COUNT_OUT_BITS'(count_ff),
                               RADIUS_BITS'(root),
                               CENTER_BITS'(c2_ff[2]),
                               CENTER_BITS'(c2_ff[1]),
                               CENTER_BITS'(c2_ff[0])};
               rsp_user_in  = dropped_ff;
               // The set is closed: the next item starts a new one.
               count_in     = '0;
               dropped_in   = 1'b0;
               state_in     = S_LOAD;
            end
         end

         default: begin
            state_in = S_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_LOAD;
         count_ff     <= '0;
         dropped_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         dropped_ff   <= dropped_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      min_ff      <= min_in;
      max_ff      <= max_in;
      c2_ff       <= c2_in;
      idx_ff      <= idx_in;
      axis_ff     <= axis_in;
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
   end

   bsp_ram #(
      .WIDTH (PT_BITS),
      .DEPTH (MAX_POINTS)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ADDR_BITS'(count_ff)),
      .wr_data ({pt[2], pt[1], pt[0]}),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   bsp_dist #(
      .COORD_BITS (COORD_BITS)
   ) u_dist (
      .clock   (clock),
      .reset   (reset),
      .ctl     (dist_ctl),
      .point   (ram_rd_data),
      .center2 ({c2_ff[2], c2_ff[1], c2_ff[0]}),
      .best    (best),
      .busy    (dist_busy)
   );

   // Very wide coordinates can push the sum of squares past 64 bits; it then
   // saturates at the top of the 64-bit range before the root.
   generate
      if (RAW_BITS > 64) begin : g_clamp
         assign sq_opnd = (|best[RAW_BITS-1:64]) ? '1 : best[63:0];
      end else begin : g_pass
         assign sq_opnd = best;
      end
   endgenerate

   bsp_isqrt #(
      .IN_BITS (SQ_BITS)
   ) u_root (
      .clock   (clock),
      .reset   (reset),
      .start   (root_start),
      .operand (sq_opnd),
      .done    (root_done),
      .root    (root)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   // The store never holds more than its capacity.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_BITS'(MAX_POINTS))
      else $error("point count above capacity");

   // A last point closes the input until the result is formed.
   a_last_closes: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && req_tlast) |=> !req_tready)
      else $error("input still open after last point");

   // A new result only appears out of the emit step.
   a_emit_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(state_ff == S_EMIT))
      else $error("result raised outside emit");

   // The squaring pipeline is empty whenever points are loading.
   a_idle_dist: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_LOAD) |-> !dist_busy)
      else $error("distance unit busy during load");

endmodule

/* rtl/core/bsp_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
// Stand-alone; no package needed.
`timescale 1ns / 1ps

module bsp_ram #(
   parameter int WIDTH = 48,
   parameter int DEPTH = 1024
) (
   input  logic                                  clock,
   input  logic                                  wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                      wr_data,
   input  logic                                  rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                      rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/core/bsp_dist.sv */
// Shared squaring unit: squares one axis offset per cycle, sums the three
// axes of a point and keeps the largest sum. Depends on bsp_pkg.
`timescale 1ns / 1ps

module bsp_dist
   import bsp_pkg::*;
#(
   parameter int COORD_BITS = DEF_COORD_BITS
) (
   input  logic                          clock,
   input  logic                          reset,
   input  dist_ctl_type                  ctl,
   input  logic [3*COORD_BITS-1:0]       point,   // x, y, z from the lowest bits
   input  logic [3*(COORD_BITS+1)-1:0]   center2, // doubled center, x lowest
   output logic [2*COORD_BITS+1:0]       best,
   output logic                          busy
);

   localparam int PROD_BITS = 2 * COORD_BITS;
   localparam int SUM_BITS  = 2 * COORD_BITS + 2;

   logic signed [COORD_BITS-1:0] p_sel;
   logic signed [COORD_BITS:0]   c_sel;
   logic signed [COORD_BITS+1:0] offset;
   logic [COORD_BITS-1:0]        mag;

   logic [PROD_BITS-1:0] prod_ff, prod_in;
   logic                 prod_valid_ff, prod_valid_in;
   logic                 prod_first_ff, prod_first_in;
   logic                 prod_last_ff, prod_last_in;
   logic [SUM_BITS-1:0]  sum_ff, sum_in;
   logic [SUM_BITS-1:0]  best_ff, best_in;
   logic [SUM_BITS-1:0]  acc;

   always_comb begin
      case (ctl.axis)
         AXIS_X: begin
            p_sel = point[0 +: COORD_BITS];
            c_sel = center2[0 +: COORD_BITS+1];
         end
         AXIS_Y: begin
            p_sel = point[COORD_BITS +: COORD_BITS];
            c_sel = center2[COORD_BITS+1 +: COORD_BITS+1];
         end
         AXIS_Z: begin
            p_sel = point[2*COORD_BITS +: COORD_BITS];
            c_sel = center2[2*(COORD_BITS+1) +: COORD_BITS+1];
         end
         default: begin
            p_sel = '0;
            c_sel = '0;
         end
      endcase
   end

   // Every stored point lies inside the box, so the doubled offset never
   // exceeds max - min in magnitude and fits COORD_BITS unsigned bits.
   assign offset = {p_sel[COORD_BITS-1], p_sel, 1'b0} - (COORD_BITS+2)'(c_sel);
   assign mag    = offset[COORD_BITS+1] ? COORD_BITS'(-offset) : COORD_BITS'(offset);

   assign acc = (prod_first_ff ? SUM_BITS'(0) : sum_ff) + SUM_BITS'(prod_ff);

   always_comb begin
      prod_in       = mag * mag;
      prod_valid_in = ctl.sq_en;
      prod_first_in = (ctl.axis == AXIS_X);
      prod_last_in  = (ctl.axis == AXIS_Z);
      sum_in        = sum_ff;
      best_in       = best_ff;
      if (prod_valid_ff) begin
         sum_in = acc;
         if (prod_last_ff && (acc > best_ff)) begin
            best_in = acc;
         end
      end
      if (ctl.clear) begin
         best_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_valid_ff <= 1'b0;
      end else begin
         prod_valid_ff <= prod_valid_in;
      end
      prod_ff       <= prod_in;
      prod_first_ff <= prod_first_in;
      prod_last_ff  <= prod_last_in;
      sum_ff        <= sum_in;
      best_ff       <= best_in;
   end

   assign best = best_ff;
   assign busy = prod_valid_ff;

endmodule

/* rtl/core/bsp_isqrt.sv */
// Iterative integer square root, one result bit per cycle (floor root).
// Depends on bsp_pkg for the DEF_COORD_BITS default of IN_BITS.
`timescale 1ns / 1ps

module bsp_isqrt
   import bsp_pkg::*;
#(
   parameter int IN_BITS = 2 * DEF_COORD_BITS + 2
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  logic [IN_BITS-1:0]     operand,
   output logic                   done,
   output logic [IN_BITS/2-1:0]   root
);

   localparam int ROOT_BITS = IN_BITS / 2;
   localparam int CNT_BITS  = $clog2(ROOT_BITS + 1);

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [CNT_BITS-1:0]   cnt_ff, cnt_in;
   logic [IN_BITS-1:0]    opnd_ff, opnd_in;
   logic [ROOT_BITS+1:0]  rem_ff, rem_in;
   logic [ROOT_BITS-1:0]  root_ff, root_in;
   logic [ROOT_BITS+1:0]  rem_try;
   logic [ROOT_BITS+1:0]  trial;
   logic                  fits;

   assign rem_try = {rem_ff[ROOT_BITS-1:0], opnd_ff[IN_BITS-1 -: 2]};
   assign trial   = {root_ff, 2'b01};
   assign fits    = (rem_try >= trial);

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      opnd_in = opnd_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_BITS'(ROOT_BITS);
         opnd_in = operand;
         rem_in  = '0;
         root_in = '0;
      end else if (busy_ff) begin
         opnd_in = {opnd_ff[IN_BITS-3:0], 2'b00};
         rem_in  = fits ? (rem_try - trial) : rem_try;
         root_in = {root_ff[ROOT_BITS-2:0], fits};
         cnt_in  = cnt_ff - 1'b1;
         if (cnt_ff == CNT_BITS'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      opnd_ff <= opnd_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
   end

   assign done = done_ff;
   assign root = root_ff;

endmodule
